// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication, off while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	`ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// File: src/crcpf_pkg.sv
package crcpf_pkg;

	localparam int unsigned LEN_W       = 10;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CRC_W       = 16;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam int unsigned MAX_PAYLOAD_DEF = 512;
	localparam int unsigned FIFO_DEPTH_DEF  = 4;

	localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h1021;
	localparam logic [BYTE_W-1:0] START_RST    = 8'h02;
	localparam logic [BYTE_W-1:0] END_RST      = 8'h03;

	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic [LEN_W-1:0]  packet_len;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              frame_end;
	} frame_t;

	typedef struct packed {
		logic              hdr;
		logic              pay;
		logic              trl;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] data;
		logic [CRC_W-1:0]  crc;
	} desc_t;

	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// File: src/crcpf_front.sv
module crcpf_front import crcpf_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	input  logic  q_full,
	output logic  q_push,
	output desc_t q_wdata
);

	logic [CRC_W-1:0] crc_q;
	logic [LEN_W-1:0] taken_q;
	logic [LEN_W-1:0] latched_q;

	logic             first;
	logic             empty;
	logic             last;
	logic [LEN_W-1:0] len_sat;
	logic [LEN_W-1:0] taken_nxt;
	logic [LEN_W-1:0] limit;
	logic [CRC_W-1:0] crc_nxt;

	assign item_ready = !q_full;
	assign q_push     = item_valid && item_ready;

	always_comb begin
		first = (taken_q == '0);
		if (32'(item.packet_len) > MAX_PAYLOAD) begin
			len_sat = LEN_W'(MAX_PAYLOAD);
		end else begin
			len_sat = item.packet_len;
		end
		empty     = first && (len_sat == '0);
		taken_nxt = first ? LEN_W'(1) : taken_q + LEN_W'(1);
		limit     = first ? len_sat : latched_q;
		last      = !empty && (taken_nxt >= limit);
		crc_nxt   = crc_feed(first ? '0 : crc_q, item.payload_byte);

		q_wdata.hdr  = first;
		q_wdata.pay  = !empty;
		q_wdata.trl  = empty || last;
		q_wdata.len  = len_sat;
		q_wdata.data = item.payload_byte;
		q_wdata.crc  = empty ? '0 : crc_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= '0;
			taken_q   <= '0;
			latched_q <= '0;
		end else if (q_push) begin
			if (empty || last) begin
				crc_q     <= '0;
				taken_q   <= '0;
				latched_q <= '0;
			end else begin
				crc_q     <= crc_nxt;
				taken_q   <= taken_nxt;
				latched_q <= limit;
			end
		end
	end

endmodule

// File: src/crcpf_fifo.sv
module crcpf_fifo import crcpf_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t wdata,
	output logic  full,
	input  logic  pop,
	output desc_t rdata,
	output logic  not_empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	desc_t         mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: src/crcpf_back.sv
module crcpf_back import crcpf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  desc_t             q_rdata,
	output logic              q_pop,
	input  logic [BYTE_W-1:0] start_marker,
	input  logic [BYTE_W-1:0] end_marker,
	output logic              frame_valid,
	input  logic              frame_ready,
	output frame_t            frame
);

	localparam int unsigned NUM_STEPS = 7;

	typedef enum logic [2:0] {
		STEP_START,
		STEP_LEN_HI,
		STEP_LEN_LO,
		STEP_DATA,
		STEP_CRC_HI,
		STEP_CRC_LO,
		STEP_END
	} step_t;

	step_t                  step_q;
	logic                   out_valid_q;
	frame_t                 out_q;

	logic [NUM_STEPS-1:0]   mask;
	logic [NUM_STEPS-1:0]   avail;
	logic [NUM_STEPS-1:0]   rest;
	step_t                  pick;
	logic                   found;
	logic                   more;
	logic                   emit;
	frame_t                 nxt;

	always_comb begin
		mask  = {q_rdata.trl, q_rdata.trl, q_rdata.trl, q_rdata.pay,
			q_rdata.hdr, q_rdata.hdr, q_rdata.hdr};
		avail = mask & (7'h7F << step_q);
		pick  = STEP_START;
		found = 1'b0;
		for (int i = 0; i < NUM_STEPS; i++) begin
			if (avail[i] && !found) begin
				pick  = step_t'(3'(i));
				found = 1'b1;
			end
		end
		rest = avail & ~(7'b1 << pick);
		more = |rest;
		emit = q_valid && (!out_valid_q || frame_ready);

		nxt.frame_end = 1'b0;
		case (pick)
			STEP_START:  nxt.frame_byte = start_marker;
			STEP_LEN_HI: nxt.frame_byte = {6'b0, q_rdata.len[LEN_W-1:8]};
			STEP_LEN_LO: nxt.frame_byte = q_rdata.len[7:0];
			STEP_DATA:   nxt.frame_byte = q_rdata.data;
			STEP_CRC_HI: nxt.frame_byte = q_rdata.crc[15:8];
			STEP_CRC_LO: nxt.frame_byte = q_rdata.crc[7:0];
			STEP_END: begin
				nxt.frame_byte = end_marker;
				nxt.frame_end  = 1'b1;
			end
			default:     nxt.frame_byte = '0;
		endcase
	end

	assign q_pop       = emit && !more;
	assign frame_valid = out_valid_q;
	assign frame       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_START;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
			out_q       <= nxt;
			step_q      <= more ? step_t'(pick + 3'd1) : STEP_START;
		end else if (frame_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: src/crc16_packet_framer.sv
// Packet framer with CRC-16 trailer.
// Item channel (item_valid/item_ready/item): one payload byte per transaction
// together with the packet length, which is taken from the first byte only.
// Frame channel (frame_valid/frame_ready/frame): one framed byte per
// transaction; frame_end marks the end marker.
// Frame: start marker, 16-bit length (big-endian), payload, CRC-16 (big-endian,
// poly 0x1021, init 0), end marker. A length of zero yields an empty frame.
// cfg_we/cfg_index/cfg_wdata write the start (0) and end (1) markers.
// The first byte caused by a transaction passes the descriptor queue and then
// the output register, which emits one byte per cycle while work is queued and
// the receiver accepts; a packet's first byte adds start marker and length, its
// last byte CRC and end marker. The descriptor queue lets input run ahead by up
// to FIFO_DEPTH transactions while the output drains header or trailer bytes.
// Reset clears the queue, the running CRC and counters and restores the markers.
// A stalled receiver holds the current byte; the queue then fills and
// item_ready drops.
`include "assert_macros.svh"

module crc16_packet_framer import crcpf_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int unsigned FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  frame_valid,
	input  logic                  frame_ready,
	output frame_t                frame,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [BYTE_W-1:0] start_marker_q;
	logic [BYTE_W-1:0] end_marker_q;

	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_valid;
	desc_t q_wdata;
	desc_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_RST;
			end_marker_q   <= END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_wdata;
				CFG_END_MARKER:   end_marker_q   <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	crcpf_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	crcpf_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.rdata    (q_rdata),
		.not_empty(q_valid)
	);

	crcpf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.start_marker(start_marker_q),
		.end_marker  (end_marker_q),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

	`ASSERT_CLK(a_out_from_queue, $rose(frame_valid) |-> $past(q_valid), "output without queued work")
	`ASSERT_IMPL(a_end_marker, frame_valid && frame.frame_end, frame.frame_byte == end_marker_q, "end byte differs from end marker")
	`ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "queue popped while empty")

endmodule
